// File: sv/fkrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkrs_pkg: shared types and constants of the float key radix sorter
// Status codes, opcodes, sequencer states and key conversion.
// ----------------------------------------------------------------------------
package fkrs_pkg;

  localparam int unsigned MaxItemsDefault  = 4096;
  localparam int unsigned DigitBitsDefault = 8;
  localparam int unsigned KeyBits          = 32;
  localparam int unsigned IndexBits        = 12;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StBusy  = 2'd3
  } status_e;

  typedef enum logic {
    OpLoad = 1'b0,
    OpRead = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    SIdle,
    SExec,
    SSeed,
    SClear,
    SOrd,
    SKey,
    SBkt,
    SUpd,
    SScanR,
    SScanW,
    SRdO,
    SRdK,
    SRdD
  } state_e;

  function automatic logic [KeyBits-1:0] make_key(input logic [KeyBits-1:0] bits);
    logic [KeyBits-1:0] k;
    if (bits[KeyBits-1]) k = ~bits;
    else k = bits | {1'b1, {(KeyBits-1){1'b0}}};
    return k;
  endfunction

endpackage

// File: sv/float_key_radix_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_key_radix_sort: LSD radix sorter for float depth keys
// Stores keys, sorts them in memory on the first read, streams them out.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         start, busy, opcode_i, depth_bits_i
// result    out        done_o, item_index_o, sort_key_o, last_item_o, status_o
//
// A load or an empty read passes through SExec and strobes done_o from the
// done register; busy drops in the same cycle. A read of a sorted set runs
// SExec, SRdO, SRdK and SRdD, then strobes done_o from the done register.
// The first read of a set also runs the sort: SSeed seeds the order, then
// each pass clears the buckets in SClear, builds the histogram with SOrd,
// SKey, SBkt and SUpd per item, scans with SScanR and SScanW per bucket and
// scatters with the same states per item. These steps follow the serial
// chain order read, key read, bucket read and write, one access per memory
// and cycle. Reset needs no clearing pass; the receiver cannot stall results.
module float_key_radix_sort #(
  parameter int unsigned MAX_ITEMS  = fkrs_pkg::MaxItemsDefault,
  parameter int unsigned DIGIT_BITS = fkrs_pkg::DigitBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] depth_bits_i,
  output logic        done_o,
  output logic [11:0] item_index_o,
  output logic [31:0] sort_key_o,
  output logic        last_item_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW      = $clog2(MAX_ITEMS);
  localparam int unsigned CW      = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NBUCK   = 1 << DIGIT_BITS;
  localparam int unsigned NPASS   = (32 + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PW      = (NPASS > 1) ? $clog2(NPASS) : 1;
  localparam int unsigned SHW     = $clog2(32 * 2);
  localparam int unsigned IW      = (CW > DIGIT_BITS + 1) ? CW : DIGIT_BITS + 1;
  // With an even number of passes the sorted order ends up in buffer A.
  localparam bit          FIN_A   = (NPASS % 2) == 0;

  // Memories.
  logic [31:0]       key_mem   [MAX_ITEMS];
  logic [AW-1:0]     ord_a_mem [MAX_ITEMS];
  logic [AW-1:0]     ord_b_mem [MAX_ITEMS];
  logic [CW-1:0]     bkt_mem   [NBUCK];

  fkrs_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     rdpos_q, rdpos_d;
  logic              sorted_q, sorted_d;
  logic [PW-1:0]     pass_q, pass_d;
  logic [IW-1:0]     i_q, i_d;
  logic [CW-1:0]     acc_q, acc_d;
  logic              scat_q, scat_d;    // second sweep of a pass: scatter
  logic              cmd_op_q;
  logic [31:0]       cmd_key_q;
  logic [AW-1:0]     ent_q, ent_d;
  logic [DIGIT_BITS-1:0] dig_q, dig_d;

  logic              done_q, done_d;
  logic [11:0]       idx_q, idx_d;
  logic [31:0]       key_q, key_d;
  logic              last_q, last_d;
  logic [1:0]        st_q, st_d;

  // Memory control.
  logic              key_we;
  logic [AW-1:0]     key_waddr, key_raddr;
  logic [31:0]       key_rdata;
  logic              oa_we, ob_we;
  logic [AW-1:0]     oa_waddr, ob_waddr, oa_raddr, ob_raddr, ord_wdata;
  logic [AW-1:0]     oa_rdata, ob_rdata;
  logic              bk_we;
  logic [DIGIT_BITS-1:0] bk_waddr, bk_raddr;
  logic [CW-1:0]     bk_wdata, bk_rdata;

  logic [AW-1:0]     src_idx;
  logic [AW-1:0]     fin_idx;
  logic [DIGIT_BITS-1:0] digit;
  logic [SHW-1:0]    shamt;
  logic              src_is_a;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= cmd_key_q;
    key_rdata <= key_mem[key_raddr];
    if (oa_we) ord_a_mem[oa_waddr] <= ord_wdata;
    oa_rdata <= ord_a_mem[oa_raddr];
    if (ob_we) ord_b_mem[ob_waddr] <= ord_wdata;
    ob_rdata <= ord_b_mem[ob_raddr];
    if (bk_we) bkt_mem[bk_waddr] <= bk_wdata;
    bk_rdata <= bkt_mem[bk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_op_q  <= opcode_i;
      cmd_key_q <= fkrs_pkg::make_key(depth_bits_i);
    end
    ent_q <= ent_d;
    dig_q <= dig_d;
  end

  // Even passes read buffer A and write B.
  assign src_is_a = !pass_q[0];
  assign src_idx  = src_is_a ? oa_rdata : ob_rdata;
  assign fin_idx  = FIN_A ? oa_rdata : ob_rdata;
  assign shamt    = SHW'(pass_q) * SHW'(DIGIT_BITS);
  assign digit    = DIGIT_BITS'(key_rdata >> shamt);
  assign busy     = (state_q != fkrs_pkg::SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fkrs_pkg::SIdle;
      count_q  <= '0;
      rdpos_q  <= '0;
      sorted_q <= 1'b0;
      pass_q   <= '0;
      i_q      <= '0;
      acc_q    <= '0;
      scat_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rdpos_q  <= rdpos_d;
      sorted_q <= sorted_d;
      pass_q   <= pass_d;
      i_q      <= i_d;
      acc_q    <= acc_d;
      scat_q   <= scat_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    key_q  <= key_d;
    last_q <= last_d;
    st_q   <= st_d;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rdpos_d  = rdpos_q;
    sorted_d = sorted_q;
    pass_d   = pass_q;
    i_d      = i_q;
    acc_d    = acc_q;
    scat_d   = scat_q;
    ent_d    = ent_q;
    dig_d    = dig_q;
    done_d   = 1'b0;
    idx_d    = idx_q;
    key_d    = key_q;
    last_d   = last_q;
    st_d     = st_q;
    key_we   = 1'b0;
    key_waddr = AW'(count_q);
    key_raddr = src_idx;
    oa_we    = 1'b0;
    ob_we    = 1'b0;
    oa_waddr = AW'(i_q);
    ob_waddr = AW'(i_q);
    oa_raddr = AW'(i_q);
    ob_raddr = AW'(i_q);
    ord_wdata = AW'(i_q);
    bk_we    = 1'b0;
    bk_waddr = DIGIT_BITS'(i_q);
    bk_raddr = DIGIT_BITS'(i_q);
    bk_wdata = '0;

    case (state_q)
      fkrs_pkg::SIdle: begin
        if (start && !busy) state_d = fkrs_pkg::SExec;
      end
      fkrs_pkg::SExec: begin
        if (cmd_op_q == fkrs_pkg::OpLoad) begin
          key_d  = cmd_key_q;
          last_d = 1'b0;
          idx_d  = '0;
          if (sorted_q) st_d = fkrs_pkg::StBusy;
          else if (count_q >= CW'(MAX_ITEMS)) st_d = fkrs_pkg::StFull;
          else begin
            st_d    = fkrs_pkg::StOk;
            idx_d   = 12'(count_q);
            key_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          done_d  = 1'b1;
          state_d = fkrs_pkg::SIdle;
        end else if (count_q == '0) begin
          st_d = fkrs_pkg::StEmpty;
          idx_d = '0; key_d = '0; last_d = 1'b0;
          done_d = 1'b1;
          state_d = fkrs_pkg::SIdle;
        end else if (sorted_q) begin
          state_d = fkrs_pkg::SRdO;
        end else begin
          i_d = '0;
          state_d = fkrs_pkg::SSeed;
        end
      end
      // Seed order A with identity, one entry per cycle.
      fkrs_pkg::SSeed: begin
        oa_we = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == IW'(count_q)) begin
          i_d = '0;
          pass_d = '0;
          state_d = fkrs_pkg::SClear;
        end
      end
      fkrs_pkg::SClear: begin
        bk_we = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q == IW'(NBUCK - 1)) begin
          i_d = '0;
          scat_d = 1'b0;
          state_d = fkrs_pkg::SOrd;
        end
      end
      // Per item: read the order entry, then its key, then its bucket.
      fkrs_pkg::SOrd: begin
        state_d = fkrs_pkg::SKey;
      end
      fkrs_pkg::SKey: begin
        key_raddr = src_idx;
        ent_d = src_idx;
        state_d = fkrs_pkg::SBkt;
      end
      fkrs_pkg::SBkt: begin
        bk_raddr = digit;
        dig_d = digit;
        state_d = fkrs_pkg::SUpd;
      end
      // Bump the bucket; in the scatter sweep its old value is the slot.
      fkrs_pkg::SUpd: begin
        bk_we    = 1'b1;
        bk_waddr = dig_q;
        bk_wdata = bk_rdata + 1'b1;
        if (scat_q) begin
          if (src_is_a) ob_we = 1'b1;
          else oa_we = 1'b1;
          oa_waddr  = AW'(bk_rdata);
          ob_waddr  = AW'(bk_rdata);
          ord_wdata = ent_q;
        end
        i_d = i_q + 1'b1;
        state_d = fkrs_pkg::SOrd;
        if (i_q + 1'b1 == IW'(count_q)) begin
          i_d = '0;
          if (!scat_q) begin
            acc_d = '0;
            state_d = fkrs_pkg::SScanR;
          end else if (pass_q == PW'(NPASS - 1)) begin
            pass_d = '0;
            sorted_d = 1'b1;
            rdpos_d = '0;
            state_d = fkrs_pkg::SRdO;
          end else begin
            pass_d = pass_q + 1'b1;
            state_d = fkrs_pkg::SClear;
          end
        end
      end
      fkrs_pkg::SScanR: begin
        state_d = fkrs_pkg::SScanW;
      end
      // Exclusive prefix sum over the buckets.
      fkrs_pkg::SScanW: begin
        bk_we    = 1'b1;
        bk_wdata = acc_q;
        acc_d    = acc_q + bk_rdata;
        i_d      = i_q + 1'b1;
        state_d  = fkrs_pkg::SScanR;
        if (i_q == IW'(NBUCK - 1)) begin
          i_d = '0;
          scat_d = 1'b1;
          state_d = fkrs_pkg::SOrd;
        end
      end
      fkrs_pkg::SRdO: begin
        oa_raddr = rdpos_q;
        ob_raddr = rdpos_q;
        state_d = fkrs_pkg::SRdK;
      end
      fkrs_pkg::SRdK: begin
        key_raddr = fin_idx;
        ent_d = fin_idx;
        state_d = fkrs_pkg::SRdD;
      end
      fkrs_pkg::SRdD: begin
        idx_d  = 12'(ent_q);
        key_d  = key_rdata;
        st_d   = fkrs_pkg::StOk;
        done_d = 1'b1;
        state_d = fkrs_pkg::SIdle;
        if (CW'(rdpos_q) + 1'b1 == count_q) begin
          last_d   = 1'b1;
          count_d  = '0;
          rdpos_d  = '0;
          sorted_d = 1'b0;
        end else begin
          last_d  = 1'b0;
          rdpos_d = rdpos_q + 1'b1;
        end
      end
      default: state_d = fkrs_pkg::SIdle;
    endcase
  end

  assign done_o       = done_q;
  assign item_index_o = idx_q;
  assign sort_key_o   = key_q;
  assign last_item_o  = last_q;
  assign status_o     = st_q;

endmodule
